@@ rtl/core/assert_macros.svh @@
// Shared assertion macros; clock aclk and reset aresetn are taken from the
// module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PGF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while in reset.
`define PGF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/pgf_pkg.sv @@
`default_nettype none

package pgf_pkg;

    localparam int IDX_W  = 6;
    localparam int SIZE_W = 7;
    localparam int FRAC_W = 6;

    localparam logic [SIZE_W-1:0] PALETTE_SIZE_RESET = 7'd64;

    // register index of the configuration port
    localparam logic REG_PALETTE_SIZE = 1'b0;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_fix;
        logic emit;
        logic reject;
    } dp_cmd_t;

    typedef struct packed {
        logic req_ok;
        logic div_last;
        logic out_free;
        logic last_entry;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/pgf_ctrl.sv @@
`default_nettype none

`include "assert_macros.svh"

module pgf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pgf_pkg::dp_status_t  status,
    output pgf_pkg::dp_cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_FIX  = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_REJ  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = status.req_ok ? ST_DIV : ST_REJ;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                cmd.div_fix = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last_entry) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REJ: begin
                if (status.out_free) begin
                    cmd.reject = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `PGF_ASSERT_NEXT(a_ramp_ends_idle, cmd.emit && status.last_entry, state_reg == ST_IDLE)
    `PGF_ASSERT_NEXT(a_bad_req_rejects, cmd.load && !status.req_ok, state_reg == ST_REJ)

endmodule

`default_nettype wire

@@ rtl/core/pgf_datapath.sv @@
`default_nettype none

`include "assert_macros.svh"

module pgf_datapath #(
    parameter int PALETTE_DEPTH = 64,
    parameter int CHANNEL_BITS  = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [CHANNEL_BITS-1:0]         s_start_red,
    input  logic [CHANNEL_BITS-1:0]         s_start_green,
    input  logic [CHANNEL_BITS-1:0]         s_start_blue,
    input  logic [CHANNEL_BITS-1:0]         s_end_red,
    input  logic [CHANNEL_BITS-1:0]         s_end_green,
    input  logic [CHANNEL_BITS-1:0]         s_end_blue,
    input  logic [pgf_pkg::IDX_W-1:0]       s_start_index,
    input  logic [pgf_pkg::IDX_W-1:0]       s_end_index,
    input  logic [pgf_pkg::SIZE_W-1:0]      palette_size,
    input  pgf_pkg::dp_cmd_t                cmd,
    output pgf_pkg::dp_status_t             status,
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic [pgf_pkg::IDX_W-1:0]       m_entry_index,
    output logic [CHANNEL_BITS-1:0]         m_entry_red,
    output logic [CHANNEL_BITS-1:0]         m_entry_green,
    output logic [CHANNEL_BITS-1:0]         m_entry_blue,
    output logic                            m_rejected,
    output logic                            m_last
);

    localparam int CB     = CHANNEL_BITS;
    localparam int IW     = pgf_pkg::IDX_W;
    localparam int SW     = pgf_pkg::SIZE_W;
    localparam int FW     = pgf_pkg::FRAC_W;
    localparam int CNT_W  = (CHANNEL_BITS > 1) ? $clog2(CHANNEL_BITS) : 1;

    logic [CB-1:0]    start_col [3];
    logic [CB-1:0]    end_col   [3];
    logic             ld_neg    [3];
    logic [CB-1:0]    ld_mag    [3];

    logic [SW-1:0]    eff_size;

    logic [IW-1:0]    base_idx_reg;
    logic [IW-1:0]    gap_reg;
    logic [IW-1:0]    off_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic             neg_reg   [3];
    logic [CB-1:0]    dvd_reg   [3];
    logic [CB-1:0]    quo_reg   [3];
    logic [FW-1:0]    rem_reg   [3];
    logic [CB-1:0]    qd_reg    [3];
    logic [FW-1:0]    rd_reg    [3];
    logic [FW-1:0]    frac_reg  [3];
    logic [CB-1:0]    col_reg   [3];

    logic [FW:0]      trial     [3];
    logic             qbit      [3];
    logic [FW-1:0]    rem_next  [3];
    logic [FW:0]      fsum      [3];
    logic             carry     [3];
    logic [FW-1:0]    frac_next [3];
    logic [CB-1:0]    col_next  [3];

    logic             m_valid_reg;
    logic [IW-1:0]    m_index_reg;
    logic [CB-1:0]    m_col_reg [3];
    logic             m_rej_reg;
    logic             m_last_reg;

    assign start_col[0] = s_start_red;
    assign start_col[1] = s_start_green;
    assign start_col[2] = s_start_blue;
    assign end_col[0]   = s_end_red;
    assign end_col[1]   = s_end_green;
    assign end_col[2]   = s_end_blue;

    assign eff_size = (palette_size > SW'(PALETTE_DEPTH)) ? SW'(PALETTE_DEPTH) : palette_size;

    assign status.req_ok     = (s_start_index < s_end_index) && ({1'b0, s_end_index} < eff_size);
    assign status.div_last   = (cnt_reg == '0);
    assign status.out_free   = !m_valid_reg || m_ready;
    assign status.last_entry = (off_reg == gap_reg);

    // per-channel: load magnitude, one restoring divide step, one ramp step
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ld_neg[k]    = end_col[k] < start_col[k];
            ld_mag[k]    = ld_neg[k] ? (start_col[k] - end_col[k]) : (end_col[k] - start_col[k]);
            trial[k]     = {rem_reg[k], dvd_reg[k][CB-1]};
            qbit[k]      = trial[k] >= {1'b0, gap_reg};
            rem_next[k]  = qbit[k] ? FW'(trial[k] - {1'b0, gap_reg}) : trial[k][FW-1:0];
            fsum[k]      = {1'b0, frac_reg[k]} + {1'b0, rd_reg[k]};
            carry[k]     = fsum[k] >= {1'b0, gap_reg};
            frac_next[k] = carry[k] ? FW'(fsum[k] - {1'b0, gap_reg}) : fsum[k][FW-1:0];
            col_next[k]  = col_reg[k] + qd_reg[k] + CB'(carry[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load) begin
            cnt_reg <= CNT_W'(CHANNEL_BITS - 1);
        end else if (cmd.div_step && cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_idx_reg <= s_start_index;
            gap_reg      <= s_end_index - s_start_index;
            off_reg      <= '0;
            for (int k = 0; k < 3; k++) begin
                neg_reg[k]  <= ld_neg[k];
                dvd_reg[k]  <= ld_mag[k];
                quo_reg[k]  <= '0;
                rem_reg[k]  <= '0;
                frac_reg[k] <= '0;
                col_reg[k]  <= start_col[k];
            end
        end
        if (cmd.div_step) begin
            for (int k = 0; k < 3; k++) begin
                dvd_reg[k] <= dvd_reg[k] << 1;
                quo_reg[k] <= CB'({quo_reg[k], qbit[k]});
                rem_reg[k] <= rem_next[k];
            end
        end
        // turn the magnitude quotient into a floored signed step
        if (cmd.div_fix) begin
            for (int k = 0; k < 3; k++) begin
                if (!neg_reg[k]) begin
                    qd_reg[k] <= quo_reg[k];
                    rd_reg[k] <= rem_reg[k];
                end else if (rem_reg[k] == '0) begin
                    qd_reg[k] <= ~quo_reg[k] + CB'(1);
                    rd_reg[k] <= '0;
                end else begin
                    qd_reg[k] <= ~quo_reg[k];
                    rd_reg[k] <= FW'(gap_reg - rem_reg[k]);
                end
            end
        end
        if (cmd.emit) begin
            off_reg <= off_reg + IW'(1);
            for (int k = 0; k < 3; k++) begin
                frac_reg[k] <= frac_next[k];
                col_reg[k]  <= col_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.reject) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_index_reg <= base_idx_reg + off_reg;
            for (int k = 0; k < 3; k++) begin
                m_col_reg[k] <= col_reg[k];
            end
            m_rej_reg   <= 1'b0;
            m_last_reg  <= status.last_entry;
        end else if (cmd.reject) begin
            m_index_reg <= '0;
            for (int k = 0; k < 3; k++) begin
                m_col_reg[k] <= '0;
            end
            m_rej_reg   <= 1'b1;
            m_last_reg  <= 1'b1;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_entry_index = m_index_reg;
    assign m_entry_red   = m_col_reg[0];
    assign m_entry_green = m_col_reg[1];
    assign m_entry_blue  = m_col_reg[2];
    assign m_rejected    = m_rej_reg;
    assign m_last        = m_last_reg;

    `PGF_ASSERT_IMP(a_reject_shape, m_valid_reg && m_rej_reg, m_last_reg && m_index_reg == '0)
    `PGF_ASSERT_NEXT(a_emit_lands, cmd.emit || cmd.reject, m_valid_reg)

endmodule

`default_nettype wire

@@ rtl/core/palette_gradient_fill_unit.sv @@
`default_nettype none

// Channel   Direction  Handshake          Carries
// s_*       in         s_valid / s_ready  two colours, start and end index
// m_*       out        m_valid / m_ready  one palette entry, rejected, last
// APB       in         psel/penable       palette_size register at 0x0
//
// Accept a request only in idle; a rejected request waits in the reject state
// for a free output register, then raises its single item and frees the input.
// A valid ramp divides the colour differences by the gap, CHANNEL_BITS quotient
// bits per channel (one quotient bit per cycle, three channels side by side),
// then fixes the sign and emits one entry per cycle while the output is free.
// Stalls on m_ready hold the ramp in place; reset sets palette_size to 64.

module palette_gradient_fill_unit #(
    parameter int PALETTE_DEPTH = 64,
    parameter int CHANNEL_BITS  = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [CHANNEL_BITS-1:0]         s_start_red,
    input  logic [CHANNEL_BITS-1:0]         s_start_green,
    input  logic [CHANNEL_BITS-1:0]         s_start_blue,
    input  logic [CHANNEL_BITS-1:0]         s_end_red,
    input  logic [CHANNEL_BITS-1:0]         s_end_green,
    input  logic [CHANNEL_BITS-1:0]         s_end_blue,
    input  logic [pgf_pkg::IDX_W-1:0]       s_start_index,
    input  logic [pgf_pkg::IDX_W-1:0]       s_end_index,
    // palette entry channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pgf_pkg::IDX_W-1:0]       m_entry_index,
    output logic [CHANNEL_BITS-1:0]         m_entry_red,
    output logic [CHANNEL_BITS-1:0]         m_entry_green,
    output logic [CHANNEL_BITS-1:0]         m_entry_blue,
    output logic                            m_rejected,
    output logic                            m_last
);

    logic [pgf_pkg::SIZE_W-1:0] palette_size_reg;
    logic                       cfg_write;
    logic                       sel_size;

    pgf_pkg::dp_cmd_t           cmd;
    pgf_pkg::dp_status_t        status;

    // Register index is the word address; byte offset bits are ignored.
    assign sel_size  = (paddr[2] == pgf_pkg::REG_PALETTE_SIZE);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Hold palette_size; writes to any other word are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_size_reg <= pgf_pkg::PALETTE_SIZE_RESET;
        end else if (cfg_write && sel_size) begin
            palette_size_reg <= pwdata[pgf_pkg::SIZE_W-1:0];
        end
    end

    assign prdata = sel_size ? {{(32 - pgf_pkg::SIZE_W){1'b0}}, palette_size_reg} : '0;

    // Sequencer: idle, divide, sign fix, emit ramp or reject.
    pgf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Dividers, ramp accumulators and the output register.
    pgf_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .CHANNEL_BITS  (CHANNEL_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_start_red   (s_start_red),
        .s_start_green (s_start_green),
        .s_start_blue  (s_start_blue),
        .s_end_red     (s_end_red),
        .s_end_green   (s_end_green),
        .s_end_blue    (s_end_blue),
        .s_start_index (s_start_index),
        .s_end_index   (s_end_index),
        .palette_size  (palette_size_reg),
        .cmd           (cmd),
        .status        (status),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_entry_index (m_entry_index),
        .m_entry_red   (m_entry_red),
        .m_entry_green (m_entry_green),
        .m_entry_blue  (m_entry_blue),
        .m_rejected    (m_rejected),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

// Ramp requests go in on s_*, palette entries come back on m_*.
// Each accepted request is expanded here into the entries it should produce.
// The monitor pops them in order and compares every field.
// The palette_size register is rewritten between phases, only once the block
// has drained.

module tb_top;

    localparam int CH_W   = 8;
    localparam int DEPTH  = 64;
    localparam int IDX_W  = pgf_pkg::IDX_W;
    localparam int SIZE_W = pgf_pkg::SIZE_W;

    // byte address of palette_size: register index times four
    localparam logic [2:0] PALETTE_SIZE_ADDR = {pgf_pkg::REG_PALETTE_SIZE, 2'b00};

    typedef struct packed {
        logic [CH_W-1:0]  start_red;
        logic [CH_W-1:0]  start_green;
        logic [CH_W-1:0]  start_blue;
        logic [CH_W-1:0]  end_red;
        logic [CH_W-1:0]  end_green;
        logic [CH_W-1:0]  end_blue;
        logic [IDX_W-1:0] start_index;
        logic [IDX_W-1:0] end_index;
    } ramp_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             rejected;
        logic             last;
    } palette_entry_t;

    // ROW_REJECT and ROW_ENDS rows carry expectations read straight off the row.
    // ROW_PREDICT rows go through the ramp predictor.
    typedef enum logic [1:0] {ROW_PREDICT, ROW_REJECT, ROW_ENDS} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        ramp_req_t req;
    } ramp_row_t;

    localparam palette_entry_t REJECT_ENTRY = '{'0, '0, '0, '0, 1'b1, 1'b1};

    logic             aclk;
    logic             aresetn;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;
    logic             s_valid;
    logic             s_ready;
    logic [CH_W-1:0]  s_start_red;
    logic [CH_W-1:0]  s_start_green;
    logic [CH_W-1:0]  s_start_blue;
    logic [CH_W-1:0]  s_end_red;
    logic [CH_W-1:0]  s_end_green;
    logic [CH_W-1:0]  s_end_blue;
    logic [IDX_W-1:0] s_start_index;
    logic [IDX_W-1:0] s_end_index;
    logic             m_valid;
    logic             m_ready;
    logic [IDX_W-1:0] m_entry_index;
    logic [CH_W-1:0]  m_entry_red;
    logic [CH_W-1:0]  m_entry_green;
    logic [CH_W-1:0]  m_entry_blue;
    logic             m_rejected;
    logic             m_last;

    palette_entry_t    pending_entries[$];
    ramp_row_t         directed_rows[$];
    logic [SIZE_W-1:0] palette_size_cfg;
    int                fault_count;
    bit                steady_tail;

    palette_gradient_fill_unit #(
        .PALETTE_DEPTH (DEPTH),
        .CHANNEL_BITS  (CH_W)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_red   (s_start_red),
        .s_start_green (s_start_green),
        .s_start_blue  (s_start_blue),
        .s_end_red     (s_end_red),
        .s_end_green   (s_end_green),
        .s_end_blue    (s_end_blue),
        .s_start_index (s_start_index),
        .s_end_index   (s_end_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_entry_index (m_entry_index),
        .m_entry_red   (m_entry_red),
        .m_entry_green (m_entry_green),
        .m_entry_blue  (m_entry_blue),
        .m_rejected    (m_rejected),
        .m_last        (m_last)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Work out one channel of the ramp.
    // The quotient is floored, so a falling ramp rounds away from the start colour.
    function automatic logic [CH_W-1:0] ramp_channel(input int from_c, input int to_c,
                                                     input int off, input int gap);
        int num;
        int quot;
        int level;
        num = off * (to_c - from_c);
        if (num >= 0)
            quot = num / gap;
        else
            quot = -((-num + gap - 1) / gap);
        level = from_c + quot;
        return level[CH_W-1:0];
    endfunction

    // Queue every entry that an accepted request should produce.
    // The palette size saturates at the depth.
    // A bad index pair yields a single rejected item.
    function automatic void predict_ramp(input ramp_req_t r);
        int             eff_size;
        int             gap;
        palette_entry_t e;
        eff_size = (palette_size_cfg > DEPTH) ? DEPTH : int'(palette_size_cfg);
        if (!(r.start_index < r.end_index && int'(r.end_index) < eff_size)) begin
            pending_entries.push_back(REJECT_ENTRY);
            return;
        end
        gap = int'(r.end_index) - int'(r.start_index);
        for (int off = 0; off <= gap; off++) begin
            e.index    = r.start_index + IDX_W'(off);
            e.red      = ramp_channel(r.start_red, r.end_red, off, gap);
            e.green    = ramp_channel(r.start_green, r.end_green, off, gap);
            e.blue     = ramp_channel(r.start_blue, r.end_blue, off, gap);
            e.rejected = 1'b0;
            e.last     = (off == gap);
            pending_entries.push_back(e);
        end
    endfunction

    // Mostly uniform, with the rails turning up often.
    function automatic logic [CH_W-1:0] pick_channel();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? {CH_W{1'b1}} : '0;
        return CH_W'($urandom_range(0, (1 << CH_W) - 1));
    endfunction

    // Build a random request for the given effective size.
    // Most requests are legal ramps with short gaps, a few have gaps of up to the
    // whole palette, and some end exactly on the size.
    // The rest are raw index noise.
    function automatic ramp_req_t random_ramp(input int eff_size);
        ramp_req_t r;
        int        gap;
        int        pick;
        r.start_red   = pick_channel();
        r.start_green = pick_channel();
        r.start_blue  = pick_channel();
        r.end_red     = pick_channel();
        r.end_green   = pick_channel();
        r.end_blue    = pick_channel();
        pick = $urandom_range(0, 19);
        if (eff_size >= 2 && pick < 14) begin
            if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(1, eff_size - 1);
            else
                gap = $urandom_range(1, (eff_size - 1 < 7) ? eff_size - 1 : 7);
            r.start_index = IDX_W'($urandom_range(0, eff_size - 1 - gap));
            r.end_index   = r.start_index + IDX_W'(gap);
        end else if (eff_size >= 1 && eff_size < DEPTH && pick < 16) begin
            // end on the size itself: one past the last legal index
            r.end_index   = IDX_W'(eff_size);
            r.start_index = IDX_W'($urandom_range(0, eff_size - 1));
        end else begin
            r.start_index = IDX_W'($urandom_range(0, DEPTH - 1));
            r.end_index   = IDX_W'($urandom_range(0, DEPTH - 1));
        end
        return r;
    endfunction

    // Present one request and hold it until accepted.
    // Queue its expectations at the accepting edge, then maybe idle for a burst.
    // Leave valid high when no gap follows, so the next item is not lowered and
    // raised again in the same step.
    task automatic send_request(input ramp_req_t r, input row_kind_t kind);
        s_valid       <= 1'b1;
        s_start_red   <= r.start_red;
        s_start_green <= r.start_green;
        s_start_blue  <= r.start_blue;
        s_end_red     <= r.end_red;
        s_end_green   <= r.end_green;
        s_end_blue    <= r.end_blue;
        s_start_index <= r.start_index;
        s_end_index   <= r.end_index;
        do @(posedge aclk); while (!s_ready);
        case (kind)
            ROW_REJECT: begin
                pending_entries.push_back(REJECT_ENTRY);
            end
            ROW_ENDS: begin
                pending_entries.push_back('{r.start_index, r.start_red, r.start_green,
                                            r.start_blue, 1'b0, 1'b0});
                pending_entries.push_back('{r.end_index, r.end_red, r.end_green,
                                            r.end_blue, 1'b0, 1'b1});
            end
            default: begin
                predict_ramp(r);
            end
        endcase
        if (!steady_tail && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every queued entry has come back.
    // Then give the output stage time to settle.
    task automatic drain_ramps();
        s_valid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write palette_size: a setup phase, then an access phase until pready.
    task automatic write_palette_size(input logic [SIZE_W-1:0] size);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PALETTE_SIZE_ADDR;
        pwdata  <= 32'(size);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        palette_size_cfg = size;
    endtask

    // Stall the result side in random bursts, with calm stretches in between.
    // Hold m_ready high throughout the final phase.
    initial begin
        m_ready = 1'b1;
        forever begin
            @(posedge aclk);
            if (!steady_tail && aresetn && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                repeat ($urandom_range(0, 15)) @(posedge aclk);
            end
        end
    end

    // Compare each accepted item with the oldest entry still expected.
    always @(posedge aclk) begin : entry_monitor
        palette_entry_t got;
        palette_entry_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_entry_index, m_entry_red, m_entry_green, m_entry_blue,
                    m_rejected, m_last};
            if (pending_entries.size() == 0) begin
                if (fault_count < 10)
                    $display("unexpected item: idx=%0d rgb=%0d/%0d/%0d rej=%0b last=%0b",
                             got.index, got.red, got.green, got.blue, got.rejected,
                             got.last);
                fault_count++;
            end else begin
                want = pending_entries.pop_front();
                if (got !== want) begin
                    if (fault_count < 10) begin
                        $display("mismatch: want idx=%0d rgb=%0d/%0d/%0d rej=%0b last=%0b",
                                 want.index, want.red, want.green, want.blue,
                                 want.rejected, want.last);
                        $display("           got idx=%0d rgb=%0d/%0d/%0d rej=%0b last=%0b",
                                 got.index, got.red, got.green, got.blue,
                                 got.rejected, got.last);
                    end
                    fault_count++;
                end
            end
        end
    end

    // Hard stop, sized for every request at full length behind the longest stalls.
    initial begin
        #(4_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int phase_size[7];
        int phase_items[7];
        int eff_size;

        aresetn          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        s_valid          = 1'b0;
        s_start_red      = '0;
        s_start_green    = '0;
        s_start_blue     = '0;
        s_end_red        = '0;
        s_end_green      = '0;
        s_end_blue       = '0;
        s_start_index    = '0;
        s_end_index      = '0;
        palette_size_cfg = pgf_pkg::PALETTE_SIZE_RESET;
        fault_count      = 0;
        steady_tail      = 1'b0;

        // Directed rows run on the reset size of 64.
        // Fields: colours start r/g/b, end r/g/b, then start index, end index.
        directed_rows.push_back('{ROW_PREDICT, '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
                                                 6'd0, 6'd63}});
        directed_rows.push_back('{ROW_PREDICT, '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0,
                                                 6'd0, 6'd63}});
        directed_rows.push_back('{ROW_ENDS, '{8'd255, 8'd0, 8'd170, 8'd0, 8'd255, 8'd85,
                                              6'd0, 6'd1}});
        directed_rows.push_back('{ROW_ENDS, '{8'h5A, 8'hA5, 8'h0F, 8'hF0, 8'h3C, 8'hC3,
                                              6'd62, 6'd63}});
        // equal indices, reversed indices, widest reversal, both zero
        directed_rows.push_back('{ROW_REJECT, '{8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60,
                                                6'd5, 6'd5}});
        directed_rows.push_back('{ROW_REJECT, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                                                8'd255, 6'd10, 6'd3}});
        directed_rows.push_back('{ROW_REJECT, '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6,
                                                6'd63, 6'd0}});
        directed_rows.push_back('{ROW_REJECT, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                                6'd0, 6'd0}});
        // gap that does not divide the differences, in both directions
        directed_rows.push_back('{ROW_PREDICT, '{8'd200, 8'd7, 8'd128, 8'd7, 8'd200, 8'd129,
                                                 6'd3, 6'd10}});
        // flat colour
        directed_rows.push_back('{ROW_PREDICT, '{8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77,
                                                 6'd20, 6'd23}});
        directed_rows.push_back('{ROW_PREDICT, '{8'd1, 8'd254, 8'd128, 8'd254, 8'd1, 8'd127,
                                                 6'd0, 6'd62}});
        directed_rows.push_back('{ROW_PREDICT, '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                                                 6'd1, 6'd63}});
        directed_rows.push_back('{ROW_PREDICT, '{8'd13, 8'd250, 8'd99, 8'd240, 8'd3, 8'd100,
                                                 6'd31, 6'd32}});

        // Random phases walk the register across its range.
        // 127 saturates to the depth; 0 and 1 reject everything; 2 leaves one
        // legal pair.
        phase_size  = '{127, 0, 1, 2, 33, 64, 0};
        phase_items = '{30, 15, 10, 20, 30, 25, 30};
        phase_size[6] = $urandom_range(3, 126);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].kind);

        for (int p = 0; p < 7; p++) begin
            drain_ramps();
            write_palette_size(SIZE_W'(phase_size[p]));
            // settle the tail phase with no idling on either side
            if (p == 6)
                steady_tail = 1'b1;
            eff_size = (phase_size[p] > DEPTH) ? DEPTH : phase_size[p];
            repeat (phase_items[p])
                send_request(random_ramp(eff_size), ROW_PREDICT);
        end

        drain_ramps();
        repeat (20) @(posedge aclk);

        if (pending_entries.size() != 0)
            fault_count++;
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
